[design/uwv_pkg.sv]
// Package for the wind vector estimator: defaults, register codes,
// fixed-point constants and the arctangent table. No dependencies.
`timescale 1ns / 1ps
package uwv_pkg;
	localparam int TIME_BITS_DEF     = 20;
	localparam int VELOCITY_BITS_DEF = 18;

	// config port
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_K     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NS_B  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EW_B  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 3'd4;

	localparam int K_W    = 20;
	localparam int RISE_W = 20;
	localparam int BIAS_W = 17;
	localparam int GAIN_W = 16;
	localparam logic [RISE_W-1:0] RISE_RESET = 20'd100000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

	// 2*K*1e6 numerator, kept in doubled nanoseconds
	localparam int NUM_W     = 41;
	localparam int NUM_SCALE = 2000000;
	localparam int MIN_T2    = 2000;   // 1 us, doubled

	// direction
	localparam int DIR_W        = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int FRAC_BITS    = 24;
	localparam int ZW           = 24;
	localparam int OCTANT_CDEG  = 4500;
	localparam int QUARTER_CDEG = 9000;
	localparam int HALF_CDEG    = 18000;
	localparam int FULL_CDEG    = 36000;

	// atan(2^-i) in 1/256 centidegree
	function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
		logic [ZW-1:0] v;
		unique case (i)
			5'd0:  v = 24'd1152000;
			5'd1:  v = 24'd680065;
			5'd2:  v = 24'd359328;
			5'd3:  v = 24'd182400;
			5'd4:  v = 24'd91554;
			5'd5:  v = 24'd45822;
			5'd6:  v = 24'd22916;
			5'd7:  v = 24'd11459;
			5'd8:  v = 24'd5730;
			5'd9:  v = 24'd2865;
			5'd10: v = 24'd1432;
			5'd11: v = 24'd716;
			5'd12: v = 24'd358;
			5'd13: v = 24'd179;
			5'd14: v = 24'd90;
			5'd15: v = 24'd45;
			5'd16: v = 24'd22;
			5'd17: v = 24'd11;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

[design/uwv_sample_if.sv]
// Input channel: four flight times per transfer.
// Depends on nothing.
`timescale 1ns / 1ps
interface uwv_sample_if #(parameter int TIME_BITS = 20);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] ns_forward_time;
	logic [TIME_BITS-1:0] ns_reverse_time;
	logic [TIME_BITS-1:0] ew_forward_time;
	logic [TIME_BITS-1:0] ew_reverse_time;
	modport source (output valid, ns_forward_time, ns_reverse_time, ew_forward_time,
		ew_reverse_time, input ready);
	modport sink (input valid, ns_forward_time, ns_reverse_time, ew_forward_time,
		ew_reverse_time, output ready);
endinterface

[design/uwv_result_if.sv]
// Output channel: smoothed wind vector, speed and direction.
// Depends on nothing.
`timescale 1ns / 1ps
interface uwv_result_if #(parameter int VELOCITY_BITS = 18);
	logic                            valid;
	logic                            ready;
	logic signed [VELOCITY_BITS-1:0] east_velocity;
	logic signed [VELOCITY_BITS-1:0] north_velocity;
	logic [VELOCITY_BITS-1:0]        wind_speed;
	logic [15:0]                     wind_bearing;
	modport source (output valid, east_velocity, north_velocity, wind_speed,
		wind_bearing, input ready);
	modport sink (input valid, east_velocity, north_velocity, wind_speed,
		wind_bearing, output ready);
endinterface

[design/uwv_div.sv]
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Depends on uwv_pkg.
`timescale 1ns / 1ps
module uwv_div #(
	parameter int DW = 23
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [uwv_pkg::NUM_W-1:0]   dividend,
	input  logic [DW-1:0]               divisor,
	output logic                        done,
	output logic [uwv_pkg::NUM_W-1:0]   quotient
);
	localparam int NW = uwv_pkg::NUM_W;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   rem_t;
	logic          fits;

	assign rem_t = {rem_q, dvd_q[NW-1]};
	assign fits  = rem_t >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(rem_t - {1'b0, div_q}) : rem_t[DW-1:0];
			dvd_q <= {dvd_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

[design/uwv_sqrt.sv]
// Digit-by-digit square root with round to nearest and saturation.
// Depends on nothing.
`timescale 1ns / 1ps
module uwv_sqrt #(
	parameter int VB = 18
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*VB-1:0] radicand,
	output logic            done,
	output logic [VB-1:0]   root
);
	localparam int RW = VB + 3;
	localparam int CW = $clog2(VB + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [2*VB-1:0] rad_q;
	logic [RW-1:0]   rem_q;
	logic [VB-1:0]   root_q;
	logic [VB-1:0]   res_q;
	logic [RW-1:0]   rem_t;
	logic [RW-1:0]   trial;
	logic [VB:0]     rinc;

	assign rem_t = {rem_q[RW-3:0], rad_q[2*VB-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign rinc  = {1'b0, root_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VB)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(VB)) begin
				// remainder above root: nearer to the next integer
				if (rem_q > RW'(root_q))
					res_q <= rinc[VB] ? '1 : rinc[VB-1:0];
				else
					res_q <= root_q;
			end else begin
				rad_q <= {rad_q[2*VB-3:0], 2'b00};
				if (rem_t >= trial) begin
					rem_q  <= rem_t - trial;
					root_q <= {root_q[VB-2:0], 1'b1};
				end else begin
					rem_q  <= rem_t;
					root_q <= {root_q[VB-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q;
endmodule

[design/uwv_cordic.sv]
// Vectoring CORDIC for the wind direction, one rotation per cycle,
// octant folded in and out around it. Depends on uwv_pkg.
`timescale 1ns / 1ps
module uwv_cordic #(
	parameter int VB = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VB-1:0]          east,
	input  logic signed [VB-1:0]          north,
	output logic                          done,
	output logic [uwv_pkg::DIR_W-1:0]     direction
);
	localparam int FB = uwv_pkg::FRAC_BITS;
	localparam int XW = VB + FB + 3;
	localparam int ZW = uwv_pkg::ZW;
	localparam int NS = uwv_pkg::CORDIC_STEPS;
	localparam int CW = $clog2(NS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic                 swap_q;
	logic                 eneg_q;
	logic                 nneg_q;
	logic                 zero_q;
	logic [uwv_pkg::DIR_W-1:0] dir_q;

	logic signed [VB:0] e_x, n_x, ae_x, an_x;
	logic [VB-1:0]      ae, an;
	logic               swap;
	logic signed [XW-1:0] xs, ys;
	logic [ZW-1:0]      ang;
	logic signed [ZW-1:0] zr, af;
	logic [12:0]        a;
	logic [13:0]        q;
	logic [16:0]        d;

	always_comb begin
		e_x  = (VB+1)'(east);
		n_x  = (VB+1)'(north);
		ae_x = e_x[VB] ? -e_x : e_x;
		an_x = n_x[VB] ? -n_x : n_x;
		ae   = ae_x[VB-1:0];
		an   = an_x[VB-1:0];
		swap = ae > an;
		xs   = x_q >>> cnt_q;
		ys   = y_q >>> cnt_q;
		ang  = uwv_pkg::atan_lut(5'(cnt_q));
		zr   = z_q + ZW'(128);
		af   = zr >>> 8;
		if (af[ZW-1])
			a = '0;
		else if (af > ZW'(uwv_pkg::OCTANT_CDEG))
			a = 13'(uwv_pkg::OCTANT_CDEG);
		else
			a = af[12:0];
		q = swap_q ? 14'(uwv_pkg::QUARTER_CDEG) - 14'(a) : 14'(a);
		priority if (!nneg_q && !eneg_q)
			d = 17'(q);
		else if (!nneg_q)
			d = 17'(uwv_pkg::FULL_CDEG) - 17'(q);
		else if (!eneg_q)
			d = 17'(uwv_pkg::HALF_CDEG) - 17'(q);
		else
			d = 17'(uwv_pkg::HALF_CDEG) + 17'(q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({{(XW-VB-FB){1'b0}}, (swap ? ae : an), {FB{1'b0}}});
			y_q    <= $signed({{(XW-VB-FB){1'b0}}, (swap ? an : ae), {FB{1'b0}}});
			z_q    <= '0;
			swap_q <= swap;
			eneg_q <= east[VB-1];
			nneg_q <= north[VB-1];
			zero_q <= (east == '0) && (north == '0);
		end else if (busy_q) begin
			if (cnt_q == CW'(NS)) begin
				if (zero_q || d >= 17'(uwv_pkg::FULL_CDEG))
					dir_q <= '0;
				else
					dir_q <= d[15:0];
			end else if (!y_q[XW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed(ang);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed(ang);
			end
		end
	end

	assign done      = done_q;
	assign direction = dir_q;
endmodule

[design/ultrasonic_wind_vector_estimator.sv]
// Top level of the wind vector estimator: config registers, sequencer,
// shared multiplier, smoothing state. Uses uwv_pkg, both channel interfaces,
// uwv_div, uwv_sqrt and uwv_cordic.
//
// Usage:
//  - sample (sink): one transfer carries four flight times in ns. ready is
//    high only while the sequencer is idle; one set is worked at a time.
//  - result (source): one transfer per set, except the first set after
//    reset, which is taken and dropped. The second set loads the estimate,
//    later sets blend into it with the Q0.16 gain in REG_GAIN.
//  - wr_en/wr_index/wr_data: register writes, only while idle. Unknown
//    indexes are ignored.
//  - Pass from the input transfer to result.valid: the four shift-subtract
//    divisions (one quotient bit a cycle) dominate, then the square root (one
//    bit a cycle) and the 18-step CORDIC; the set that loads the estimate
//    skips the blend states S_BN and S_BE. ready returns only when the
//    sequencer is back in idle after the pass, so a new set is taken only
//    once the last one has left S_FIN.
//  - Reset (arst_n low) restores the register defaults, clears both
//    estimates and rearms the drop of the first set.
//  - If the receiver stalls, the result waits in the output register; the
//    next set may be taken and worked, and it waits at the end for the
//    output register to drain.
`timescale 1ns / 1ps
module ultrasonic_wind_vector_estimator #(
	parameter int TIME_BITS     = uwv_pkg::TIME_BITS_DEF,
	parameter int VELOCITY_BITS = uwv_pkg::VELOCITY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [uwv_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [uwv_pkg::CFG_DATA_W-1:0]    wr_data,
	uwv_sample_if.sink                        sample,
	uwv_result_if.source                      result
);
	localparam int VB = VELOCITY_BITS;
	localparam int NW = uwv_pkg::NUM_W;
	// doubled, corrected flight time
	localparam int DW = ((TIME_BITS > uwv_pkg::RISE_W) ? TIME_BITS : uwv_pkg::RISE_W) + 3;
	localparam int MA = ((VB + 1) > (uwv_pkg::K_W + 1)) ? (VB + 1) : (uwv_pkg::K_W + 1);
	localparam int MB = (VB > 22) ? VB : 22;
	localparam int PW = MA + MB;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_K     = 5'd1;
	localparam logic [4:0] S_KW    = 5'd2;
	localparam logic [4:0] S_DIV   = 5'd3;
	localparam logic [4:0] S_DIVW  = 5'd4;
	localparam logic [4:0] S_MEAS  = 5'd5;
	localparam logic [4:0] S_UPD   = 5'd6;
	localparam logic [4:0] S_BN    = 5'd7;
	localparam logic [4:0] S_BE    = 5'd8;
	localparam logic [4:0] S_SQ1   = 5'd9;
	localparam logic [4:0] S_SQ2   = 5'd10;
	localparam logic [4:0] S_SQ3   = 5'd11;
	localparam logic [4:0] S_SQRT  = 5'd12;
	localparam logic [4:0] S_SQRTW = 5'd13;
	localparam logic [4:0] S_ATAN  = 5'd14;
	localparam logic [4:0] S_ATANW = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;

	localparam logic [1:0] PH_DROP = 2'd0;
	localparam logic [1:0] PH_LOAD = 2'd1;
	localparam logic [1:0] PH_RUN  = 2'd2;

	// config
	logic [uwv_pkg::K_W-1:0]           k_q;
	logic [uwv_pkg::RISE_W-1:0]        rise_q;
	logic signed [uwv_pkg::BIAS_W-1:0] nsb_q;
	logic signed [uwv_pkg::BIAS_W-1:0] ewb_q;
	logic [uwv_pkg::GAIN_W-1:0]        gain_q;

	logic [4:0] state_q;
	logic [1:0] phase_q;
	logic [1:0] idx_q;

	logic signed [DW-1:0] t2_q [4];   // ns fwd, ns rev, ew fwd, ew rev
	logic [NW-1:0]        quo_q [4];
	logic [NW-1:0]        num_q;
	logic signed [PW-1:0] prod_q;
	logic signed [VB-1:0] meas_n_q, meas_e_q;
	logic signed [VB-1:0] est_n_q, est_e_q;
	logic [2*VB-1:0]      sum_q;
	logic [VB-1:0]        speed_q;

	logic                 ovalid_q;
	logic signed [VB-1:0] o_e_q, o_n_q;
	logic [VB-1:0]        o_spd_q;
	logic [15:0]          o_dir_q;

	logic                 take;
	logic signed [DW-1:0] rise2, nsb_x, ewb_x;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic [DW-1:0]        divisor;
	logic                 div_start, div_done;
	logic [NW-1:0]        div_quo;
	logic                 sq_start, sq_done;
	logic [VB-1:0]        sq_root;
	logic                 at_start, at_done;
	logic [15:0]          at_dir;
	logic signed [VB:0]   dn, de;
	logic                 out_free;

	function automatic logic signed [DW-1:0] twice(input logic [TIME_BITS-1:0] t);
		return $signed({{(DW-TIME_BITS-1){1'b0}}, t, 1'b0});
	endfunction

	// axis velocity from both quotients, 0 unless both times exceed 1 us
	function automatic logic signed [VB-1:0] axis_vel(
		input logic signed [DW-1:0] tf, input logic signed [DW-1:0] tr,
		input logic [NW-1:0] qf, input logic [NW-1:0] qr);
		logic signed [NW:0]   diff;
		logic signed [VB-1:0] v;
		diff = $signed({1'b0, qf}) - $signed({1'b0, qr});
		if (tf <= DW'(uwv_pkg::MIN_T2) || tr <= DW'(uwv_pkg::MIN_T2))
			v = '0;
		else if (diff > $signed((NW+1)'({1'b0, {(VB-1){1'b1}}})))
			v = {1'b0, {(VB-1){1'b1}}};
		else if (diff < -$signed((NW+1)'({1'b1, {(VB-1){1'b0}}})))
			v = {1'b1, {(VB-1){1'b0}}};
		else
			v = diff[VB-1:0];
		return v;
	endfunction

	// est + p/65536, rounded half away from zero
	function automatic logic signed [VB-1:0] blend(
		input logic signed [VB-1:0] est, input logic signed [PW-1:0] p);
		logic [PW-1:0]      mag;
		logic [PW-1:0]      stp;
		logic signed [VB:0] e_x;
		logic signed [VB:0] r;
		mag = p[PW-1] ? PW'(-p) : PW'(p);
		stp = (mag + PW'(32768)) >> 16;
		e_x = (VB+1)'(est);
		r   = p[PW-1] ? e_x - $signed(stp[VB:0]) : e_x + $signed(stp[VB:0]);
		return r[VB-1:0];
	endfunction

	assign take     = sample.valid && sample.ready;
	assign out_free = !ovalid_q || result.ready;
	assign sample.ready = (state_q == S_IDLE);

	assign rise2 = $signed({{(DW-uwv_pkg::RISE_W-1){1'b0}}, rise_q, 1'b0});
	assign nsb_x = DW'(nsb_q);
	assign ewb_x = DW'(ewb_q);
	assign dn    = (VB+1)'(meas_n_q) - (VB+1)'(est_n_q);
	assign de    = (VB+1)'(meas_e_q) - (VB+1)'(est_e_q);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_K: begin
				mul_a = $signed({{(MA-uwv_pkg::K_W){1'b0}}, k_q});
				mul_b = MB'(uwv_pkg::NUM_SCALE);
			end
			S_UPD: begin
				mul_a = MA'(dn);
				mul_b = $signed({{(MB-uwv_pkg::GAIN_W){1'b0}}, gain_q});
			end
			S_BN: begin
				mul_a = MA'(de);
				mul_b = $signed({{(MB-uwv_pkg::GAIN_W){1'b0}}, gain_q});
			end
			S_SQ1: begin
				mul_a = MA'(est_n_q);
				mul_b = MB'(est_n_q);
			end
			S_SQ2: begin
				mul_a = MA'(est_e_q);
				mul_b = MB'(est_e_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    divisor = t2_q[0];
			2'd1:    divisor = t2_q[1];
			2'd2:    divisor = t2_q[2];
			default: divisor = t2_q[3];
		endcase
	end

	assign div_start = (state_q == S_DIV);
	assign sq_start  = (state_q == S_SQRT);
	assign at_start  = (state_q == S_ATAN);

	uwv_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(num_q),
		.divisor(divisor), .done(div_done), .quotient(div_quo));

	uwv_sqrt #(.VB(VB)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sum_q),
		.done(sq_done), .root(sq_root));

	uwv_cordic #(.VB(VB)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(at_start), .east(est_e_q),
		.north(est_n_q), .done(at_done), .direction(at_dir));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			rise_q <= uwv_pkg::RISE_RESET;
			nsb_q  <= '0;
			ewb_q  <= '0;
			gain_q <= uwv_pkg::GAIN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				uwv_pkg::REG_K:    k_q    <= wr_data[uwv_pkg::K_W-1:0];
				uwv_pkg::REG_RISE: rise_q <= wr_data[uwv_pkg::RISE_W-1:0];
				uwv_pkg::REG_NS_B: nsb_q  <= $signed(wr_data[uwv_pkg::BIAS_W-1:0]);
				uwv_pkg::REG_EW_B: ewb_q  <= $signed(wr_data[uwv_pkg::BIAS_W-1:0]);
				uwv_pkg::REG_GAIN: gain_q <= wr_data[uwv_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and smoothing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_DROP;
			idx_q    <= '0;
			est_n_q  <= '0;
			est_e_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (result.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (phase_q == PH_DROP)
							phase_q <= PH_LOAD;
						else
							state_q <= S_K;
					end
				end
				S_K:  state_q <= S_KW;
				S_KW: begin
					idx_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						if (idx_q == 2'd3)
							state_q <= S_MEAS;
						else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_MEAS: state_q <= S_UPD;
				S_UPD: begin
					if (phase_q == PH_LOAD) begin
						est_n_q <= meas_n_q;
						est_e_q <= meas_e_q;
						phase_q <= PH_RUN;
						state_q <= S_SQ1;
					end else
						state_q <= S_BN;
				end
				S_BN: begin
					est_n_q <= blend(est_n_q, prod_q);
					state_q <= S_BE;
				end
				S_BE: begin
					est_e_q <= blend(est_e_q, prod_q);
					state_q <= S_SQ1;
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQ3;
				S_SQ3: state_q <= S_SQRT;
				S_SQRT: state_q <= S_SQRTW;
				S_SQRTW: if (sq_done) state_q <= S_ATAN;
				S_ATAN: state_q <= S_ATANW;
				S_ATANW: if (at_done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (take) begin
			t2_q[0] <= twice(sample.ns_forward_time) - rise2 - nsb_x;
			t2_q[1] <= twice(sample.ns_reverse_time) - rise2 + nsb_x;
			t2_q[2] <= twice(sample.ew_forward_time) - rise2 - ewb_x;
			t2_q[3] <= twice(sample.ew_reverse_time) - rise2 + ewb_x;
		end
		if (state_q == S_KW)
			num_q <= prod_q[NW-1:0];
		if (state_q == S_DIVW && div_done)
			quo_q[idx_q] <= div_quo;
		if (state_q == S_MEAS) begin
			meas_n_q <= axis_vel(t2_q[0], t2_q[1], quo_q[0], quo_q[1]);
			meas_e_q <= axis_vel(t2_q[2], t2_q[3], quo_q[2], quo_q[3]);
		end
		if (state_q == S_SQ2)
			sum_q <= prod_q[2*VB-1:0];
		if (state_q == S_SQ3)
			sum_q <= sum_q + prod_q[2*VB-1:0];
		if (state_q == S_SQRTW && sq_done)
			speed_q <= sq_root;
		if (state_q == S_FIN && out_free) begin
			o_e_q   <= est_e_q;
			o_n_q   <= est_n_q;
			o_spd_q <= speed_q;
			o_dir_q <= at_dir;
		end
	end

	assign result.valid          = ovalid_q;
	assign result.east_velocity  = o_e_q;
	assign result.north_velocity = o_n_q;
	assign result.wind_speed     = o_spd_q;
	assign result.wind_bearing   = o_dir_q;
endmodule

[tb/ultrasonic_wind_vector_estimator_tb.sv]
// Self-checking bench for ultrasonic_wind_vector_estimator: a directed set, then random flight
// time sets under several register settings, with random idle cycles on both channels.
// Depends on uwv_pkg, uwv_sample_if, uwv_result_if and the estimator itself.
`timescale 1ns / 1ps
module ultrasonic_wind_vector_estimator_tb;
	localparam int TB_TW   = 20;
	localparam int TB_VW   = 18;
	localparam int TMAX    = (1 << TB_TW) - 1;
	localparam int DRAIN   = 400;   // longer than a pass through the block

	typedef struct {
		logic [TB_TW-1:0] nsf, nsr, ewf, ewr;
	} flight_set_t;

	typedef struct {
		logic signed [TB_VW-1:0]   east, north;
		logic [TB_VW-1:0]          speed;
		logic [uwv_pkg::DIR_W-1:0] dir;
	} wind_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [uwv_pkg::CFG_INDEX_W-1:0] wr_index = '0;
	logic [uwv_pkg::CFG_DATA_W-1:0]  wr_data = '0;

	uwv_sample_if #(.TIME_BITS(TB_TW)) smp ();
	uwv_result_if #(.VELOCITY_BITS(TB_VW)) res ();

	ultrasonic_wind_vector_estimator u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.sample(smp), .result(res)
	);

	always #6 clk = ~clk;

	// shadow copy of the registers and smoothing state
	longint path_k, rise_ns, ns_bias, ew_bias, gain;
	longint est_east, est_north;
	int     warmup;

	flight_set_t  pending_sets[$];
	wind_report_t awaited_reports[$];
	int  error_count = 0;
	bit  hold_sender = 1'b0;   // while set, each set waits for every awaited report
	bit  no_gaps = 1'b0;       // back-to-back stretch on both sides

	// axis velocity in mm/s from doubled, corrected flight times
	function automatic longint axis_speed(longint tf, longint tr, longint bias);
		longint f2, r2, num, v;
		f2 = 2 * tf - 2 * rise_ns - bias;
		r2 = 2 * tr - 2 * rise_ns + bias;
		if (f2 <= uwv_pkg::MIN_T2 || r2 <= uwv_pkg::MIN_T2)
			return 0;
		num = path_k * uwv_pkg::NUM_SCALE;
		v = num / f2 - num / r2;
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v;
	endfunction

	// gain-weighted step toward the new measurement, half away from zero
	function automatic longint smooth(longint est, longint meas);
		longint p, mag, stp;
		p = (meas - est) * gain;
		mag = p < 0 ? -p : p;
		stp = (mag + 32768) >>> 16;
		return p < 0 ? est - stp : est + stp;
	endfunction

	function automatic longint root_nearest(longint unsigned s);
		longint unsigned r, b, x;
		r = 0;
		b = 64'd1 << 62;
		x = s;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	function automatic longint bearing_cdeg(longint e, longint n);
		longint ae, an, x, y, z, xs, ys, a, q, d;
		bit swp;
		longint atn[18] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
			5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11};
		if (e == 0 && n == 0)
			return 0;
		ae = e < 0 ? -e : e;
		an = n < 0 ? -n : n;
		swp = ae > an;
		x = (swp ? ae : an) <<< uwv_pkg::FRAC_BITS;
		y = (swp ? an : ae) <<< uwv_pkg::FRAC_BITS;
		z = 0;
		for (int i = 0; i < uwv_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atn[i];
			end else begin
				x -= ys; y += xs; z -= atn[i];
			end
		end
		a = (z + 128) >>> 8;
		if (a < 0) a = 0;
		if (a > uwv_pkg::OCTANT_CDEG) a = uwv_pkg::OCTANT_CDEG;
		q = swp ? uwv_pkg::QUARTER_CDEG - a : a;
		if (n >= 0) d = (e >= 0) ? q : uwv_pkg::FULL_CDEG - q;
		else d = (e >= 0) ? uwv_pkg::HALF_CDEG - q : uwv_pkg::HALF_CDEG + q;
		if (d >= uwv_pkg::FULL_CDEG) d = 0;
		return d;
	endfunction

	// advance the shadow state by one accepted set; queue the report it yields
	task automatic predict_wind(flight_set_t s);
		longint mn, me, sp;
		wind_report_t w;
		mn = axis_speed(s.nsf, s.nsr, ns_bias);
		me = axis_speed(s.ewf, s.ewr, ew_bias);
		if (warmup == 0) begin
			warmup = 1;     // first set after reset is dropped
			return;
		end
		if (warmup == 1) begin
			est_east = me;
			est_north = mn;
			warmup = 2;
		end else begin
			est_east = smooth(est_east, me);
			est_north = smooth(est_north, mn);
		end
		sp = root_nearest(est_east * est_east + est_north * est_north);
		if (sp > 262143) sp = 262143;
		w.east = est_east[TB_VW-1:0];
		w.north = est_north[TB_VW-1:0];
		w.speed = sp[TB_VW-1:0];
		w.dir = uwv_pkg::DIR_W'(bearing_cdeg(est_east, est_north));
		awaited_reports.push_back(w);
	endtask

	// sender: a set is loaded only when the channel is free, then a random gap follows
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		flight_set_t s;
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.ns_forward_time <= '0;
			smp.ns_reverse_time <= '0;
			smp.ew_forward_time <= '0;
			smp.ew_reverse_time <= '0;
			send_gap <= 0;
		end else begin
			if (smp.valid && smp.ready)
				predict_wind('{smp.ns_forward_time, smp.ns_reverse_time,
					smp.ew_forward_time, smp.ew_reverse_time});
			if (!(smp.valid && !smp.ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					smp.valid <= 1'b0;
				end else if ((!hold_sender || awaited_reports.size() == 0) &&
						pending_sets.size() > 0) begin
					s = pending_sets.pop_front();
					smp.ns_forward_time <= s.nsf;
					smp.ns_reverse_time <= s.nsr;
					smp.ew_forward_time <= s.ewf;
					smp.ew_reverse_time <= s.ewr;
					smp.valid <= 1'b1;
					send_gap <= no_gaps ? 0 : $urandom_range(0, 3);
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall after each transfer, field-by-field compare
	int stall;
	always @(posedge clk or negedge arst_n) begin
		wind_report_t w;
		int nxt;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall <= 0;
		end else begin
			nxt = stall;
			if (res.valid && res.ready) begin
				if (awaited_reports.size() == 0) begin
					$error("unexpected result transfer");
					error_count++;
				end else begin
					w = awaited_reports.pop_front();
					if (res.east_velocity !== w.east) begin
						$error("east_velocity exp %0d got %0d", w.east, res.east_velocity);
						error_count++;
					end
					if (res.north_velocity !== w.north) begin
						$error("north_velocity exp %0d got %0d", w.north, res.north_velocity);
						error_count++;
					end
					if (res.wind_speed !== w.speed) begin
						$error("wind_speed exp %0d got %0d", w.speed, res.wind_speed);
						error_count++;
					end
					if (res.wind_bearing !== w.dir) begin
						$error("wind_bearing exp %0d got %0d", w.dir, res.wind_bearing);
						error_count++;
					end
				end
				nxt = no_gaps ? 0 : $urandom_range(0, 3);
			end
			if (nxt > 0) begin
				res.ready <= 1'b0;
				stall <= nxt - 1;
			end else begin
				res.ready <= 1'b1;
				stall <= 0;
			end
		end
	end

	// register write; shadow copy follows (only ever done while idle)
	task automatic write_reg(logic [uwv_pkg::CFG_INDEX_W-1:0] idx, longint val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[uwv_pkg::CFG_DATA_W-1:0];
		case (idx)
			uwv_pkg::REG_K:    path_k = val & 20'hFFFFF;
			uwv_pkg::REG_RISE: rise_ns = val & 20'hFFFFF;
			uwv_pkg::REG_NS_B: ns_bias = longint'(signed'(val[uwv_pkg::BIAS_W-1:0]));
			uwv_pkg::REG_EW_B: ew_bias = longint'(signed'(val[uwv_pkg::BIAS_W-1:0]));
			uwv_pkg::REG_GAIN: gain = val & 16'hFFFF;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait for the sender and the receiver to empty out, plus the drop-path tail
	task automatic settle();
		while (pending_sets.size() > 0 || smp.valid || awaited_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [TB_TW-1:0] clip(longint v);
		if (v < 0) return '0;
		if (v > TMAX) return TB_TW'(TMAX);
		return v[TB_TW-1:0];
	endfunction

	// plausible path pair around a common transit time, skewed by wind
	function automatic void push_pair(output logic [TB_TW-1:0] f, output logic [TB_TW-1:0] r);
		longint base, d;
		base = rise_ns + $urandom_range(1000, 300000);
		d = $urandom_range(0, 32'(base / 40 + 1));
		if ($urandom_range(0, 1)) d = -d;
		f = clip(base - d);
		r = clip(base + d);
	endfunction

	task automatic add_random(int count);
		flight_set_t s;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				push_pair(s.nsf, s.nsr);
				push_pair(s.ewf, s.ewr);
			end else if (kind == 7) begin
				// one path near the 1 us floor
				push_pair(s.nsf, s.nsr);
				s.ewf = clip(rise_ns + $urandom_range(900, 1100));
				s.ewr = clip(rise_ns + $urandom_range(900, 1100));
			end else begin
				s.nsf = TB_TW'($urandom);
				s.nsr = TB_TW'($urandom);
				s.ewf = TB_TW'($urandom);
				s.ewr = TB_TW'($urandom);
			end
			pending_sets.push_back(s);
		end
	endtask

	task automatic add_set(longint a, longint b, longint c, longint d);
		flight_set_t s;
		s.nsf = clip(a); s.nsr = clip(b); s.ewf = clip(c); s.ewr = clip(d);
		pending_sets.push_back(s);
	endtask

	initial begin
		path_k = 0; rise_ns = uwv_pkg::RISE_RESET; ns_bias = 0; ew_bias = 0;
		gain = uwv_pkg::GAIN_RESET;
		est_east = 0; est_north = 0; warmup = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: K is zero, so the first reported vector is zero (direction 0)
		add_set(0, 0, 0, 0);
		add_set(150000, 150000, 150000, 150000);
		settle();

		write_reg(uwv_pkg::REG_K, 200000);
		// sender waits for every awaited report before each directed set
		hold_sender = 1'b1;
		// directed: extremes, the 1 us floor, all four quadrants, saturation
		add_set(TMAX, TMAX, TMAX, TMAX);
		add_set(rise_ns + 1000, rise_ns + 1000, rise_ns + 1000, rise_ns + 1000);
		add_set(rise_ns + 1001, rise_ns + 1002, rise_ns + 1002, rise_ns + 1001);
		add_set(rise_ns + 1001, TMAX, rise_ns + 1001, TMAX);
		add_set(TMAX, rise_ns + 1001, TMAX, rise_ns + 1001);
		add_set(200000, 201000, 200000, 201000);
		add_set(201000, 200000, 200000, 201000);
		add_set(201000, 200000, 201000, 200000);
		add_set(200000, 201000, 201000, 200000);
		add_set(200000, 201000, 150000, 150000);
		add_set(150000, 150000, 200000, 201000);
		add_set(150000, 150000, 150000, 150000);
		add_set(0, TMAX, TMAX, 0);
		add_set(rise_ns + 999, rise_ns + 5000, rise_ns + 5000, rise_ns + 999);
		settle();
		hold_sender = 1'b0;
		add_random(170);
		settle();

		// extremes: largest K, no rise time, opposite bias limits, full gain
		write_reg(uwv_pkg::REG_K, 1048575);
		write_reg(uwv_pkg::REG_RISE, 0);
		write_reg(uwv_pkg::REG_NS_B, -65536);
		write_reg(uwv_pkg::REG_EW_B, 65535);
		write_reg(uwv_pkg::REG_GAIN, 65535);
		no_gaps = 1'b1;
		add_random(150);
		settle();
		no_gaps = 1'b0;

		// largest rise time: every path reads short; zero gain freezes the estimate
		write_reg(uwv_pkg::REG_RISE, 1048575);
		write_reg(uwv_pkg::REG_GAIN, 0);
		add_random(40);
		settle();

		// mid settings, zero K, and writes to unused indexes that must be ignored
		write_reg(uwv_pkg::REG_K, 0);
		write_reg(uwv_pkg::REG_RISE, 20000);
		write_reg(uwv_pkg::REG_GAIN, 30000);
		write_reg(3'd5, 1048575);
		write_reg(3'd7, 12345);
		add_random(40);
		settle();

		write_reg(uwv_pkg::REG_K, 300000);
		write_reg(uwv_pkg::REG_NS_B, 12345);
		write_reg(uwv_pkg::REG_EW_B, -777);
		add_random(180);
		settle();

		write_reg(uwv_pkg::REG_K, 1);
		write_reg(uwv_pkg::REG_RISE, 0);
		write_reg(uwv_pkg::REG_NS_B, 65535);
		write_reg(uwv_pkg::REG_EW_B, -65536);
		write_reg(uwv_pkg::REG_GAIN, 1);
		add_random(150);
		settle();

		if (error_count == 0)
			$display("ultrasonic_wind_vector_estimator_tb: clean");
		else
			$display("ultrasonic_wind_vector_estimator_tb: errors");
		$finish;
	end

	// watchdog: ends a run that hangs
	initial begin
		#30_000_000;
		$display("ultrasonic_wind_vector_estimator_tb: errors");
		$finish;
	end
endmodule

[ultrasonic_wind_vector_estimator.f]
design/uwv_pkg.sv
design/uwv_sample_if.sv
design/uwv_result_if.sv
design/uwv_div.sv
design/uwv_sqrt.sv
design/uwv_cordic.sv
design/ultrasonic_wind_vector_estimator.sv
tb/ultrasonic_wind_vector_estimator_tb.sv
